// ----- rtl/head_insert_value_list_core_defines.svh -----
// Assertion macros for the head-insert value list core.
// Included by the top level; relies on i_clk and i_rst_n in the including scope.
`ifndef HEAD_INSERT_VALUE_LIST_CORE_DEFINES_SVH
`define HEAD_INSERT_VALUE_LIST_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HIVL_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hivl assertion failed");

// next-cycle implication, checked outside reset
`define HIVL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hivl assertion failed");

`endif

// ----- rtl/hivl_pkg.sv -----
// Shared types and constants for the head-insert value list core.
// No dependencies; imported by hivl_cell and head_insert_value_list_core.
package hivl_pkg;

    localparam int VALUE_W = 32;
    localparam int OP_W    = 2;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_PUSH,
        CMD_PULL,
        CMD_CLEAR
    } t_cell_cmd;

    // per-cell control: shared command plus this cell's pull select
    typedef struct packed {
        t_cell_cmd cmd;
        logic      pull_sel;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_ISO,
        ST_APPLY
    } t_state;

endpackage

// ----- rtl/hivl_cell.sv -----
// One list cell: holds one entry and its valid bit, compares against the key,
// and takes data from its head-side or tail-side neighbor. Uses hivl_pkg.
module hivl_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hivl_pkg::t_cell_ctl         i_ctl,
    input  logic [hivl_pkg::VALUE_W-1:0] i_key,
    input  logic [hivl_pkg::VALUE_W-1:0] i_prev_data,
    input  logic                        i_prev_valid,
    input  logic [hivl_pkg::VALUE_W-1:0] i_next_data,
    input  logic                        i_next_valid,
    output logic [hivl_pkg::VALUE_W-1:0] o_data,
    output logic                        o_valid,
    output logic                        o_match
);
    import hivl_pkg::*;

    logic [VALUE_W-1:0] r_data, n_data;
    logic               r_valid, n_valid;

    // next contents from the shared command
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        case (i_ctl.cmd)
            CMD_HOLD: begin
            end
            CMD_PUSH: begin
                n_data  = i_prev_data;
                n_valid = i_prev_valid;
            end
            CMD_PULL: begin
                if (i_ctl.pull_sel) begin
                    n_data  = i_next_data;
                    n_valid = i_next_valid;
                end
            end
            CMD_CLEAR: begin
                n_data  = '0;
                n_valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_data  <= n_data;
            r_valid <= n_valid;
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_match = r_valid && (r_data == i_key);

endmodule

// ----- rtl/head_insert_value_list_core.sv -----
// Head-insert value list: an ordered list of up to DEPTH 32-bit entries, newest at
// position 0, built as a row of hivl_cell instances. Uses hivl_pkg and the defines header.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one transaction: i_op and i_value.
//   i_op: insert at head, search, remove first match, clear.
//   Output channel (o_out_valid / i_out_stall) returns one result transaction per
//   input: found, position of first match from the head, count, empty flag, overflow.
//   The result is registered after a compare step, a first-match isolate step and an
//   update step; the update step waits while a pending result has not yet been taken.
//   A transaction is taken only when the compare/isolate/update sequence is idle, so a
//   new transaction is not accepted until the previous one has finished its update.
//   All cells compare in parallel; the first match is found with a two's-complement
//   lowest-set-bit isolate over the match vector.
//   Receiver stall: the result holds in the output register; a following transaction
//   is still accepted and finishes its compare and isolate, then waits in its update
//   step until the pending result is taken.
//   Reset (synchronous, active low): the list is emptied, every cell is zeroed,
//   and no result is pending.
`include "head_insert_value_list_core_defines.svh"

module head_insert_value_list_core #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [hivl_pkg::OP_W-1:0]     i_op,
    input  logic signed [hivl_pkg::VALUE_W-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [hivl_pkg::POS_W-1:0]    o_position,
    output logic [hivl_pkg::COUNT_W-1:0]  o_count,
    output logic                          o_empty_res,
    output logic                          o_overflow
);
    import hivl_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (IW > POS_W) ? IW : POS_W;
    localparam int UW = (CW > COUNT_W) ? CW : COUNT_W;

    t_state             r_state, n_state;
    t_op                r_op;
    logic [VALUE_W-1:0] r_val;
    logic [CW-1:0]      r_used, n_used;
    logic [DEPTH-1:0]   r_match;
    logic [DEPTH-1:0]   r_first;

    logic               r_out_valid;
    logic               r_found;
    logic [POS_W-1:0]   r_pos;
    logic [COUNT_W-1:0] r_count;
    logic               r_empty;
    logic               r_ovf;

    logic [VALUE_W-1:0] cell_data  [DEPTH];
    logic [DEPTH-1:0]   cell_valid;
    logic [DEPTH-1:0]   match_vec;
    logic [DEPTH-1:0]   pull_mask;
    t_cell_cmd          cell_cmd;
    logic               in_fire;
    logic               out_free;
    logic               apply_go;
    logic               hit;
    logic               full;
    logic [PW-1:0]      pos_enc;
    logic [UW-1:0]      used_ext;

    assign in_fire  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign hit      = |r_first;
    assign full     = (r_used == CW'(DEPTH));

    // cells at or past the first match pull from their tail-side neighbor
    assign pull_mask = ~(r_first - 1'b1);

    // position of the isolated first match
    always_comb begin
        pos_enc = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (r_first[i]) begin
                pos_enc = pos_enc | PW'(i);
            end
        end
    end

    // row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_W-1:0] prev_data, next_data;
        logic               prev_valid, next_valid;
        t_cell_ctl          ctl;

        if (g == 0) begin : g_head
            assign prev_data  = r_val;
            assign prev_valid = 1'b1;
        end else begin : g_mid_prev
            assign prev_data  = cell_data[g-1];
            assign prev_valid = cell_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign next_data  = '0;
            assign next_valid = 1'b0;
        end else begin : g_mid_next
            assign next_data  = cell_data[g+1];
            assign next_valid = cell_valid[g+1];
        end

        assign ctl.cmd      = cell_cmd;
        assign ctl.pull_sel = pull_mask[g];

        hivl_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_key        (r_val),
            .i_prev_data  (prev_data),
            .i_prev_valid (prev_valid),
            .i_next_data  (next_data),
            .i_next_valid (next_valid),
            .o_data       (cell_data[g]),
            .o_valid      (cell_valid[g]),
            .o_match      (match_vec[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_fire) n_state = ST_CMP;
            ST_CMP:   n_state = ST_ISO;
            ST_ISO:   n_state = ST_APPLY;
            ST_APPLY: if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // state outputs: stall, update strobe, cell command and next entry count
    always_comb begin
        o_in_stall = 1'b1;
        apply_go   = 1'b0;
        cell_cmd   = CMD_HOLD;
        n_used     = r_used;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_CMP, ST_ISO: begin
            end
            ST_APPLY: begin
                apply_go = out_free;
                if (out_free) begin
                    case (r_op)
                        OP_INSERT: begin
                            if (!full) begin
                                cell_cmd = CMD_PUSH;
                                n_used   = r_used + 1'b1;
                            end
                        end
                        OP_SEARCH: begin
                        end
                        OP_REMOVE: begin
                            if (hit) begin
                                cell_cmd = CMD_PULL;
                                n_used   = r_used - 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            cell_cmd = CMD_CLEAR;
                            n_used   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    assign used_ext = UW'(n_used);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            if (apply_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // transaction capture, match vector and first-match isolate
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op  <= t_op'(i_op);
            r_val <= i_value;
        end
        if (r_state == ST_CMP) begin
            r_match <= match_vec;
        end
        if (r_state == ST_ISO) begin
            r_first <= r_match & (~r_match + 1'b1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (apply_go) begin
            r_found <= hit && ((r_op == OP_SEARCH) || (r_op == OP_REMOVE));
            r_pos   <= ((r_op == OP_SEARCH) || (r_op == OP_REMOVE)) ? pos_enc[POS_W-1:0]
                                                                    : '0;
            r_count <= used_ext[COUNT_W-1:0];
            r_empty <= (n_used == '0);
            r_ovf   <= (r_op == OP_INSERT) && full;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_position  = r_pos;
    assign o_count     = r_count;
    assign o_empty_res = r_empty;
    assign o_overflow  = r_ovf;

    // checks
    `HIVL_ASSERT_NOW(a_used_matches_cells, 1'b1, $countones(cell_valid) == r_used)
    `HIVL_ASSERT_NOW(a_first_onehot, r_state == ST_APPLY, $onehot0(r_first))
    `HIVL_ASSERT_NEXT(a_accept_starts_compare, in_fire, r_state == ST_CMP)
    `HIVL_ASSERT_NOW(a_used_bound, 1'b1, r_used <= CW'(DEPTH))

endmodule
